// File: rtl/hdt_pkg.sv
`timescale 1ns / 1ps

package hdt_pkg;

    // Input commands.
    localparam logic [1:0] CMD_ADV     = 2'd0;
    localparam logic [1:0] CMD_WR_CNT  = 2'd1;
    localparam logic [1:0] CMD_DIV_RST = 2'd2;

    // Configuration register indexes.
    localparam int         CFG_IDX_W   = 2;
    localparam logic [1:0] CFG_RATE    = 2'd0;
    localparam logic [1:0] CFG_RELOAD  = 2'd1;
    localparam logic [1:0] CFG_DSPEED  = 2'd2;

    // Timer constants.
    localparam int TCNT_SPAN   = 256;
    localparam int TFRAC_LIMIT = 511;
    localparam int TFRAC_BITS  = 9;
    localparam int TL_W        = 18;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic raw;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic timer_run;
        logic div_needed;
        logic div_last;
    } t_dp_stat;

    // Timer fraction shift for each rate select code.
    function automatic logic [2:0] rate_shift(input logic [1:0] sel);
        logic [2:0] sh;
        unique case (sel)
            2'd0: sh = 3'd0;
            2'd1: sh = 3'd6;
            2'd2: sh = 3'd4;
            default: sh = 3'd2;
        endcase
        return sh;
    endfunction

endpackage

// File: rtl/hdt_in_if.sv
`timescale 1ns / 1ps

interface hdt_in_if #(
    parameter int CYCLE_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            cmd;
    logic [CYCLE_BITS-1:0] cycles;
    logic [7:0]            write_data;

    modport source (output valid, output cmd, output cycles, output write_data, input ready);
    modport sink   (input valid, input cmd, input cycles, input write_data, output ready);
endinterface

// File: rtl/hdt_out_if.sv
`timescale 1ns / 1ps

interface hdt_out_if;
    logic        valid;
    logic        ready;
    logic        timer_irq;
    logic [7:0]  divider_value;
    logic [7:0]  counter_value;
    logic [17:0] cycles_to_overflow;

    modport source (output valid, output timer_irq, output divider_value,
                    output counter_value, output cycles_to_overflow, input ready);
    modport sink   (input valid, input timer_irq, input divider_value,
                    input counter_value, input cycles_to_overflow, output ready);
endinterface

// File: rtl/hdt_ctrl.sv
`timescale 1ns / 1ps

module hdt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  hdt_pkg::t_dp_stat i_stat,
    output hdt_pkg::t_dp_cmd  o_cmd
);
    import hdt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RAW  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.timer_run ? S_RAW : S_OUT;
            end
            S_RAW: begin
                o_cmd.raw = 1'b1;
                n_state   = i_stat.div_needed ? S_DIV : S_OUT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid holds until the result transaction completes.
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && !i_out_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/hdt_dp.sv
`timescale 1ns / 1ps

module hdt_dp #(
    parameter int CYCLE_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hdt_pkg::t_dp_cmd                i_cmd,
    output hdt_pkg::t_dp_stat               o_stat,
    input  logic                            i_cfg_we,
    input  logic [hdt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [7:0]                      i_cfg_data,
    input  logic [1:0]                      i_in_cmd,
    input  logic [CYCLE_BITS-1:0]           i_in_cycles,
    input  logic [7:0]                      i_in_write_data,
    output logic                            o_timer_irq,
    output logic [7:0]                      o_divider_value,
    output logic [7:0]                      o_counter_value,
    output logic [hdt_pkg::TL_W-1:0]        o_cycles_to_overflow
);
    import hdt_pkg::*;

    localparam int CW    = CYCLE_BITS + 1;
    localparam int DSW   = ((CW + 1 > 8) ? CW + 1 : 8) + 1;
    localparam int TSW   = CYCLE_BITS + 8;
    localparam int QW    = TSW - TFRAC_BITS;
    localparam int RAWW  = ((QW > 8) ? QW : 8) + 1;
    localparam int STEPW = $clog2(RAWW + 1);

    // Configuration registers.
    logic [2:0]             r_rate;
    logic [7:0]             r_reload;
    logic                   r_dspeed;

    // Architectural state.
    logic [7:0]             r_dfrac;
    logic [7:0]             r_div;
    logic [TFRAC_BITS-1:0]  r_tfrac;
    logic [7:0]             r_counter;

    // Working registers of the current transaction.
    logic [1:0]             r_cmd;
    logic [CW-1:0]          r_c;
    logic [7:0]             r_wdata;
    logic [TSW-1:0]         r_tsum;
    logic                   r_irq;
    logic [7:0]             r_rem;
    logic [RAWW-1:0]        r_dvd;
    logic [STEPW-1:0]       r_step;

    logic [2:0]             sh;
    logic [DSW-1:0]         dsum;
    logic [TSW-1:0]         tsum;
    logic [RAWW-1:0]        raw;
    logic [RAWW-1:0]        excess;
    logic [8:0]             period;
    logic                   raw_over;
    logic                   fits;
    logic [8:0]             rem2;
    logic [8:0]             rem_next;
    logic [9:0]             tl_a;
    logic [TL_W-1:0]        time_left;

    assign sh = rate_shift(r_rate[1:0]);

    // Fraction sums for an advance.
    assign dsum = DSW'(r_dfrac) + (DSW'(r_c) << 1);
    assign tsum = TSW'(r_tfrac) + (TSW'(r_c) << sh);

    // Overflow check on the raw counter value.
    assign raw      = RAWW'(r_counter) + RAWW'(r_tsum >> TFRAC_BITS);
    assign raw_over = (raw >= RAWW'(TCNT_SPAN));
    assign excess   = raw - RAWW'(TCNT_SPAN);
    assign period   = 9'(TCNT_SPAN) - 9'(r_reload);
    assign fits     = (excess < RAWW'(period));

    // One restoring remainder step per cycle.
    assign rem2     = {r_rem, r_dvd[RAWW-1]};
    assign rem_next = (rem2 >= period) ? (rem2 - period) : rem2;

    // Counts until the next overflow, from the current state.
    assign tl_a = 10'(TFRAC_LIMIT) - 10'(r_tfrac) + (10'd1 << sh);
    always_comb begin
        if (r_rate[2]) begin
            time_left = TL_W'(tl_a >> sh)
                      + (TL_W'(8'hff - r_counter) << (4'd9 - 4'(sh)));
        end else begin
            time_left = '0;
        end
    end

    assign o_stat.timer_run  = (r_cmd == CMD_ADV) && r_rate[2];
    assign o_stat.div_needed = raw_over && !fits;
    assign o_stat.div_last   = (r_step == STEPW'(1));

    // Configuration and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate    <= '0;
            r_reload  <= '0;
            r_dspeed  <= 1'b0;
            r_dfrac   <= '0;
            r_div     <= '0;
            r_tfrac   <= '0;
            r_counter <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RATE:   r_rate   <= i_cfg_data[2:0];
                    CFG_RELOAD: r_reload <= i_cfg_data;
                    CFG_DSPEED: r_dspeed <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec) begin
                unique case (r_cmd)
                    CMD_ADV: begin
                        r_dfrac <= dsum[7:0];
                        r_div   <= r_div + 8'(dsum >> 8);
                        if (r_rate[2]) begin
                            r_tfrac <= tsum[TFRAC_BITS-1:0];
                        end
                    end
                    CMD_WR_CNT: r_counter <= r_wdata;
                    CMD_DIV_RST: r_div <= '0;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.raw) begin
                if (!raw_over) begin
                    r_counter <= raw[7:0];
                end else if (fits) begin
                    r_counter <= r_reload + excess[7:0];
                end
            end
            if (i_cmd.div_step && o_stat.div_last) begin
                r_counter <= r_reload + rem_next[7:0];
            end
        end
    end

    // Transaction working registers and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_in_cmd;
            r_c     <= CW'(i_in_cycles) << r_dspeed;
            r_wdata <= i_in_write_data;
            r_irq   <= 1'b0;
        end
        if (i_cmd.exec) begin
            r_tsum <= tsum;
        end
        if (i_cmd.raw && raw_over) begin
            r_irq  <= 1'b1;
            r_dvd  <= excess;
            r_rem  <= '0;
            r_step <= STEPW'(RAWW);
        end
        if (i_cmd.div_step) begin
            r_rem  <= rem_next[7:0];
            r_dvd  <= r_dvd << 1;
            r_step <= r_step - STEPW'(1);
        end
        if (i_cmd.out_load) begin
            o_timer_irq          <= r_irq;
            o_divider_value      <= r_div;
            o_counter_value      <= r_counter;
            o_cycles_to_overflow <= time_left;
        end
    end

endmodule

// File: rtl/handheld_divider_timer_block.sv
`timescale 1ns / 1ps

// Divider and programmable timer of a handheld console.
// Input channel i_in_chan carries one command per transaction: advance by a
// cycle count, write the timer counter, or clear the divider. Every input
// transaction produces exactly one result transaction on o_out_chan, giving
// the interrupt flag, the divider, the counter and the counts left until the
// next counter overflow.
// Configuration (rate control, reload value, double speed) is written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only while the
// block is idle, since the block itself does not enforce this.
// Counter writes, divider clears and advances with the timer off pass through
// the EXEC and OUT states; a timer advance with at most one wrap adds the RAW
// state; when the counter wraps several times, the bit-serial remainder unit
// in the DIV state then folds the excess into the reload period.
// One transaction is in flight at a time: a new input is accepted as soon as
// the result sits in the output register, even if the receiver has not taken
// it. If the receiver stalls, the result is held and a second finished result
// waits in the controller until the register frees.
// Synchronous reset clears the configuration, the divider and timer state and
// the output valid flag.
module handheld_divider_timer_block #(
    parameter int CYCLE_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hdt_in_if.sink                        i_in_chan,
    hdt_out_if.source                     o_out_chan,
    input  logic                          i_cfg_we,
    input  logic [hdt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data
);
    import hdt_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer.
    hdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_chan.valid),
        .o_in_ready  (i_in_chan.ready),
        .o_out_valid (o_out_chan.valid),
        .i_out_ready (o_out_chan.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // Arithmetic and state.
    hdt_dp #(
        .CYCLE_BITS (CYCLE_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (dp_cmd),
        .o_stat               (dp_stat),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_in_cmd             (i_in_chan.cmd),
        .i_in_cycles          (i_in_chan.cycles),
        .i_in_write_data      (i_in_chan.write_data),
        .o_timer_irq          (o_out_chan.timer_irq),
        .o_divider_value      (o_out_chan.divider_value),
        .o_counter_value      (o_out_chan.counter_value),
        .o_cycles_to_overflow (o_out_chan.cycles_to_overflow)
    );

endmodule

// File: bench/tb_handheld_divider_timer_block.sv
`timescale 1ns / 1ps

module tb_handheld_divider_timer_block;

    import hdt_pkg::*;

    localparam int         CYCLE_BITS = 12;
    localparam logic [1:0] CMD_NONE   = 2'd3;
    localparam int         PHASES     = 8;
    localparam int         PHASE_CMDS = 150;

    // One reading returned by the block for each command.
    typedef struct packed {
        logic        irq;
        logic [7:0]  divider;
        logic [7:0]  counter;
        logic [17:0] to_overflow;
    } t_reading;

    // Tracks the divider and timer state and the readings still owed by the block.
    class t_timer_checker;
        logic [2:0] rate;
        logic [7:0] reload;
        logic       dspeed;
        logic [7:0] div_frac;
        logic [7:0] divider;
        logic [8:0] tick_frac;
        logic [7:0] counter;
        t_reading   expected_readings[$];
        int         errors;
        int         readings;
        int         overflows;
        int         by_cmd[4];
        int         settings;

        function new();
            rate      = '0;
            reload    = '0;
            dspeed    = 1'b0;
            div_frac  = '0;
            divider   = '0;
            tick_frac = '0;
            counter   = '0;
            errors    = 0;
            readings  = 0;
            overflows = 0;
            settings  = 0;
            foreach (by_cmd[i]) by_cmd[i] = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [7:0] data);
            case (idx)
                CFG_RATE:   rate = data[2:0];
                CFG_RELOAD: reload = data;
                CFG_DSPEED: dspeed = data[0];
                default: ;
            endcase
        endfunction

        // Shift applied to the count for the selected rate: 0, 6, 4 or 2.
        function logic [2:0] fraction_shift();
            logic [1:0] neg;
            neg = 2'(2'd0 - rate[1:0]);
            return {neg, 1'b0};
        endfunction

        // Count (after doubling) still needed before the counter next wraps.
        function logic [17:0] counts_to_wrap();
            int unsigned sh;
            int unsigned left;
            if (!rate[2]) begin
                return '0;
            end
            sh   = fraction_shift();
            left = ((32'd511 - tick_frac + (32'd1 << sh)) >> sh)
                 + ((32'd255 - counter) << (9 - sh));
            return left[17:0];
        endfunction

        // Applies one accepted command and queues the reading it must produce.
        function void note_command(logic [1:0] cmd, logic [CYCLE_BITS-1:0] cycles,
                                   logic [7:0] wdata);
            t_reading    r;
            int unsigned c;
            int unsigned acc;
            int unsigned raw;
            r     = '0;
            by_cmd[cmd]++;
            case (cmd)
                CMD_ADV: begin
                    c        = int'(cycles) << dspeed;
                    acc      = div_frac + (c << 1);
                    divider  = 8'(divider + (acc >> 8));
                    div_frac = acc[7:0];
                    if (rate[2]) begin
                        acc       = tick_frac + (c << fraction_shift());
                        raw       = counter + (acc >> 9);
                        tick_frac = acc[8:0];
                        // Several wraps fold into the reload period; one interrupt.
                        if (raw >= 256) begin
                            r.irq = 1'b1;
                            raw   = reload + ((raw - 256) % (256 - reload));
                        end
                        counter = raw[7:0];
                    end
                end
                CMD_WR_CNT: counter = wdata;
                CMD_DIV_RST: divider = '0;
                default: ;
            endcase
            r.divider     = divider;
            r.counter     = counter;
            r.to_overflow = counts_to_wrap();
            expected_readings.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_reading(t_reading got);
            t_reading want;
            readings++;
            if (got.irq === 1'b1) overflows++;
            if (expected_readings.size() == 0) begin
                report($sformatf("reading %h arrived with nothing outstanding", got));
                return;
            end
            want = expected_readings.pop_front();
            if (got.irq !== want.irq)
                report($sformatf("timer_irq %b, wanted %b", got.irq, want.irq));
            if (got.divider !== want.divider)
                report($sformatf("divider_value %0d, wanted %0d", got.divider, want.divider));
            if (got.counter !== want.counter)
                report($sformatf("counter_value %0d, wanted %0d", got.counter, want.counter));
            if (got.to_overflow !== want.to_overflow)
                report($sformatf("cycles_to_overflow %0d, wanted %0d",
                                 got.to_overflow, want.to_overflow));
        endtask

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       cfg_we;
    logic [1:0] cfg_idx;
    logic [7:0] cfg_data;
    bit         idle_on;
    int         stall_left;
    t_timer_checker chk;

    hdt_in_if #(.CYCLE_BITS(CYCLE_BITS)) in_chan ();
    hdt_out_if out_chan ();

    handheld_divider_timer_block #(.CYCLE_BITS(CYCLE_BITS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (in_chan),
        .o_out_chan (out_chan),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Receiving side: checks each completed transaction and stalls in bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && out_chan.valid && out_chan.ready) begin
            chk.check_reading({out_chan.timer_irq, out_chan.divider_value,
                               out_chan.counter_value, out_chan.cycles_to_overflow});
        end
        if (stall_left > 0) begin
            stall_left--;
            out_chan.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            out_chan.ready <= 1'b0;
        end else begin
            out_chan.ready <= 1'b1;
        end
    end

    // Presents one command and waits for the transaction, with an optional gap first.
    task automatic send_item(logic [1:0] cmd, logic [CYCLE_BITS-1:0] cycles,
                             logic [7:0] wdata);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_chan.valid      <= 1'b1;
        in_chan.cmd        <= cmd;
        in_chan.cycles     <= cycles;
        in_chan.write_data <= wdata;
        do @(posedge i_clk); while (!in_chan.ready);
        chk.note_command(cmd, cycles, wdata);
    endtask

    // Stops sending and waits until every outstanding reading has come back.
    task automatic wait_drained();
        in_chan.valid <= 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        chk.set_register(idx, data);
    endtask

    task automatic apply_settings(logic [2:0] rate, logic [7:0] reload, logic ds);
        wait_drained();
        write_reg(CFG_RATE, {5'd0, rate});
        write_reg(CFG_RELOAD, reload);
        write_reg(CFG_DSPEED, {7'd0, ds});
        chk.settings++;
    endtask

    // Mostly short advances, with full-range counts and both extremes mixed in.
    function automatic logic [CYCLE_BITS-1:0] pick_cycles();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4, 5: return CYCLE_BITS'($urandom_range(0, 63));
            6, 7: return CYCLE_BITS'($urandom_range(0, 1023));
            default: return CYCLE_BITS'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic send_random(output bit counted);
        int         pick;
        logic [7:0] wdata;
        pick    = $urandom_range(0, 99);
        wdata   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(240, 255))
                                              : 8'($urandom_range(0, 255));
        counted = 1'b1;
        if (pick < 72) begin
            send_item(CMD_ADV, pick_cycles(), 8'($urandom_range(0, 255)));
        end else if (pick < 84) begin
            send_item(CMD_WR_CNT, CYCLE_BITS'($urandom_range(0, 4095)), wdata);
        end else if (pick < 94) begin
            send_item(CMD_DIV_RST, CYCLE_BITS'($urandom_range(0, 4095)), wdata);
        end else begin
            send_item(CMD_NONE, CYCLE_BITS'($urandom_range(0, 4095)), wdata);
            counted = 1'b0;
        end
    endtask

    initial begin
        logic [2:0] rate;
        logic [7:0] reload;
        bit         counted;
        int         sent;

        chk                = new();
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        in_chan.valid      = 1'b0;
        in_chan.cmd        = CMD_ADV;
        in_chan.cycles     = '0;
        in_chan.write_data = '0;
        out_chan.ready     = 1'b0;
        stall_left         = 0;
        idle_on            = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Timer disabled at reset: extremes of the count, the unused code and both writes.
        send_item(CMD_ADV, '0, 8'd0);
        send_item(CMD_ADV, '1, 8'd0);
        send_item(CMD_NONE, '1, 8'hff);
        send_item(CMD_DIV_RST, '0, 8'd0);
        send_item(CMD_WR_CNT, '0, 8'hff);
        send_item(CMD_WR_CNT, '1, 8'h00);

        // Slowest rate, reload at zero: a single wrap from near the top.
        apply_settings(3'd4, 8'd0, 1'b0);
        send_item(CMD_WR_CNT, '0, 8'hfe);
        send_item(CMD_ADV, '1, 8'd0);
        send_item(CMD_ADV, 12'd1, 8'd0);
        send_item(CMD_DIV_RST, '0, 8'd0);

        // Reload at the top gives a period of one; double speed on.
        apply_settings(3'd7, 8'hff, 1'b1);
        send_item(CMD_WR_CNT, '0, 8'hff);
        send_item(CMD_ADV, '1, 8'd0);
        send_item(CMD_ADV, '0, 8'd0);

        // Fastest rate: many wraps at once, then exactly one counter step.
        apply_settings(3'd5, 8'h80, 1'b0);
        send_item(CMD_ADV, '1, 8'd0);
        send_item(CMD_ADV, 12'd8, 8'd0);
        send_item(CMD_WR_CNT, '0, 8'hff);
        send_item(CMD_ADV, 12'd8, 8'd0);

        // Timer disabled with a non-zero rate select: counter and fraction hold.
        apply_settings(3'd3, 8'h80, 1'b0);
        send_item(CMD_ADV, '1, 8'd0);
        send_item(CMD_WR_CNT, '0, 8'd77);
        send_item(CMD_DIV_RST, '0, 8'd0);

        // Random phases, each under its own register setting; the last ones run without gaps.
        for (int p = 0; p < PHASES; p++) begin
            idle_on = (p < PHASES - 2);
            case (p)
                0: apply_settings(3'd7, 8'hff, 1'b1);
                1: apply_settings(3'd0, 8'h00, 1'b0);
                2: apply_settings(3'd4, 8'h00, 1'b0);
                default: begin
                    rate   = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                         : 3'($urandom_range(4, 7));
                    reload = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(250, 255))
                                                         : 8'($urandom_range(0, 255));
                    apply_settings(rate, reload, 1'($urandom_range(0, 1)));
                end
            endcase
            sent = 0;
            while (sent < PHASE_CMDS) begin
                send_random(counted);
                if (counted) sent++;
                if (p == 3 && sent == PHASE_CMDS / 2) wait_drained();
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("Covered %0d advances, %0d counter writes, %0d divider clears, %0d unused codes",
                 chk.by_cmd[CMD_ADV], chk.by_cmd[CMD_WR_CNT], chk.by_cmd[CMD_DIV_RST],
                 chk.by_cmd[CMD_NONE]);
        $display("over %0d register settings; %0d readings compared, %0d with an overflow",
                 chk.settings, chk.readings, chk.overflows);
        if (chk.errors == 0 && chk.pending() == 0) begin
            $display("tb_handheld_divider_timer_block: clean");
        end else begin
            $display("tb_handheld_divider_timer_block: errors");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("timeout with %0d readings outstanding", chk.pending());
        $display("tb_handheld_divider_timer_block: errors");
        $finish;
    end

endmodule
